@@ sv/annexb_keyframe_indexer_assert.svh @@
// Assertion helpers shared by the keyframe indexer modules.
// Each helper expects clk_i and rst_ni to be visible where it is used.
`ifndef ANNEXB_KEYFRAME_INDEXER_ASSERT_SVH
`define ANNEXB_KEYFRAME_INDEXER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define AKFI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define AKFI_ASSERT_IMP(lbl, ante, cons, msg) \
  `AKFI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ sv/akfi_pkg.sv @@
`default_nettype none

package akfi_pkg;

  // Result buffer sizing. Two free entries are needed to take a byte.
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W      = 2;
  localparam int RES_CNT_W      = 3;

  localparam int FIELD_W   = 31;
  localparam int TDATA_W   = 96;
  localparam int HIST_DEPTH = 5;
  localparam int FILL_W    = 3;

  localparam logic [FIELD_W-1:0] COUNT_MAX = 31'h7fff_ffff;

  // NAL unit types of interest.
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;

  typedef enum logic {
    KIND_KEYFRAME = 1'b0,
    KIND_SUMMARY  = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e       kind;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] picture_index;
    logic [FIELD_W-1:0] keyframe_total;
    logic               final_result;
  } result_t;

  // Which of the two write slots carry a result this cycle.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

@@ sv/annexb_keyframe_indexer.sv @@
// H.264 Annex B keyframe indexer. Bytes of an elementary stream enter on the
// slave stream port, one per transfer, with tlast on the final byte. The block
// looks for 00 00 01 start codes and judges each one when the byte four places
// after it arrives, reading the NAL type and the first-slice bit. An IDR
// picture that follows a sequence parameter set and then a picture parameter
// set produces a keyframe result (tuser 0) carrying the byte offset of that
// SPS start code (one byte earlier when a zero byte leads it), the number of
// pictures before it and the running keyframe count. The final byte produces
// a summary result (tuser 1) with the picture and keyframe totals, after which
// all tracking returns to its reset state. tlast on the master side marks the
// last result caused by one input byte. The block takes one byte per clock
// cycle: all per-byte work is a single pass of compare and counter logic on
// the history registers, and results land in a four-entry result buffer in the
// following cycle. tready drops only while that buffer has fewer than two free
// entries, since one byte can produce two results and the buffer drains one
// per cycle while m_axis_tready_i is high. Counters saturate at 2**31-1, and
// the byte position saturates at 2**POSITION_WIDTH-1.
`default_nettype none

module annexb_keyframe_indexer #(
  parameter int POSITION_WIDTH = 31
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] stream_byte
  input  wire         s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [akfi_pkg::TDATA_W-1:0] m_axis_tdata_o,
                                        // [30:0] start_offset, [61:31] picture_index,
                                        // [92:62] keyframe_total, [95:93] zero
  output logic        m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // final_result
);
  import akfi_pkg::*;

  localparam int PW = POSITION_WIDTH;

  // Stream history: slot 0 is the oldest byte, slot 4 the newest.
  logic [7:0]         hist_q [HIST_DEPTH];
  logic [7:0]         hist_d [HIST_DEPTH];
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [PW-1:0]      sps_off_q, sps_off_d;
  logic               sps_seen_q, sps_seen_d;
  logic               pps_seen_q, pps_seen_d;
  logic [FIELD_W-1:0] pic_cnt_q, pic_cnt_d;
  logic [FIELD_W-1:0] key_cnt_q, key_cnt_d;

  logic               accept;
  logic               last;
  logic [7:0]         cur;
  logic               sc_hit;
  logic [4:0]         nal_type;
  logic [PW-1:0]      at;
  logic [PW-1:0]      sc_off;
  logic               new_pic;
  logic               keyframe;
  logic [FIELD_W-1:0] key_cnt_new;
  logic [FIELD_W-1:0] pic_cnt_new;

  push_t              push;
  result_t            key_res;
  result_t            sum_res;
  result_t            slot0;
  result_t            out_res;
  logic               space;

  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = space;
  assign last            = s_axis_tlast_i;
  assign cur             = s_axis_tdata_i;

  // Start code window sits in slots 1..3, the NAL header byte in slot 4, and
  // the incoming byte carries the first-slice mark in its top bit.
  always_comb begin
    sc_hit   = (fill_q >= FILL_W'(4)) && (hist_q[1] == 8'h00) &&
               (hist_q[2] == 8'h00) && (hist_q[3] == 8'h01);
    nal_type = hist_q[4][4:0];
    at       = (pos_q >= PW'(4)) ? pos_q - PW'(4) : '0;
    // A leading zero only counts when it is a received byte.
    sc_off   = ((fill_q == FILL_W'(HIST_DEPTH)) && (hist_q[0] == 8'h00) && (at != '0))
               ? at - 1'b1 : at;
    new_pic  = sc_hit && ((nal_type == NAL_SLICE) || (nal_type == NAL_IDR)) && cur[7];
    keyframe = new_pic && (nal_type == NAL_IDR) && sps_seen_q && pps_seen_q;

    key_cnt_new = key_cnt_q;
    if (keyframe && (key_cnt_q != COUNT_MAX)) begin
      key_cnt_new = key_cnt_q + 1'b1;
    end
    pic_cnt_new = pic_cnt_q;
    if (new_pic && (pic_cnt_q != COUNT_MAX)) begin
      pic_cnt_new = pic_cnt_q + 1'b1;
    end
  end

  // Tracking state update for one accepted byte.
  always_comb begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist_d[k] = hist_q[k];
    end
    fill_d     = fill_q;
    pos_d      = pos_q;
    sps_off_d  = sps_off_q;
    sps_seen_d = sps_seen_q;
    pps_seen_d = pps_seen_q;
    pic_cnt_d  = pic_cnt_q;
    key_cnt_d  = key_cnt_q;

    if (accept) begin
      if (last) begin
        // End of stream: everything goes back to its reset value.
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist_d[k] = '0;
        end
        fill_d     = '0;
        pos_d      = '0;
        sps_off_d  = '0;
        sps_seen_d = 1'b0;
        pps_seen_d = 1'b0;
        pic_cnt_d  = '0;
        key_cnt_d  = '0;
      end else begin
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
          hist_d[k] = hist_q[k+1];
        end
        hist_d[HIST_DEPTH-1] = cur;
        if (fill_q != FILL_W'(HIST_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        if (pos_q != '1) begin
          pos_d = pos_q + 1'b1;
        end
        pic_cnt_d = pic_cnt_new;
        key_cnt_d = key_cnt_new;
        if (sc_hit) begin
          if (nal_type == NAL_SPS) begin
            sps_off_d  = sc_off;
            sps_seen_d = 1'b1;
            pps_seen_d = 1'b0;
          end else if (nal_type == NAL_PPS) begin
            if (sps_seen_q) begin
              pps_seen_d = 1'b1;
            end
          end else if (new_pic) begin
            // Any new picture drops the pending parameter sets.
            sps_seen_d = 1'b0;
            pps_seen_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist_q[k] <= hist_d[k];
    end
    sps_off_q <= sps_off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      sps_seen_q <= 1'b0;
      pps_seen_q <= 1'b0;
      pic_cnt_q  <= '0;
      key_cnt_q  <= '0;
    end else begin
      fill_q     <= fill_d;
      pos_q      <= pos_d;
      sps_seen_q <= sps_seen_d;
      pps_seen_q <= pps_seen_d;
      pic_cnt_q  <= pic_cnt_d;
      key_cnt_q  <= key_cnt_d;
    end
  end

  // Result assembly. A keyframe always goes ahead of the summary.
  always_comb begin
    key_res.kind           = KIND_KEYFRAME;
    key_res.start_offset   = FIELD_W'(sps_off_q);
    key_res.picture_index  = pic_cnt_q;
    key_res.keyframe_total = key_cnt_new;
    key_res.final_result   = !last;

    sum_res.kind           = KIND_SUMMARY;
    sum_res.start_offset   = '0;
    sum_res.picture_index  = pic_cnt_new;
    sum_res.keyframe_total = key_cnt_new;
    sum_res.final_result   = 1'b1;

    push.first  = accept && (keyframe || last);
    push.second = accept && keyframe && last;
    slot0       = keyframe ? key_res : sum_res;
  end

  akfi_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (slot0),
    .data1_i (sum_res),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tdata_o = {3'b000, out_res.keyframe_total, out_res.picture_index,
                           out_res.start_offset};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.final_result;

`include "annexb_keyframe_indexer_assert.svh"

  `AKFI_ASSERT(a_last_clears, (accept && last) |=> ((fill_q == '0) && (pos_q == '0) && (pic_cnt_q == '0)), "state not cleared after final byte")
  `AKFI_ASSERT_IMP(a_fill_tracks_pos, fill_q < FILL_W'(HIST_DEPTH), pos_q == PW'(fill_q), "history fill and position disagree")
  `AKFI_ASSERT_IMP(a_pps_needs_sps, pps_seen_q, sps_seen_q, "PPS armed without SPS")

endmodule

`default_nettype wire

@@ sv/akfi_rfifo.sv @@
`default_nettype none

module akfi_rfifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  akfi_pkg::push_t        push_i,
  input  akfi_pkg::result_t      data0_i,
  input  akfi_pkg::result_t      data1_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire                    ready_i,
  output akfi_pkg::result_t      data_o
);
  import akfi_pkg::*;

  result_t              entry_q [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic                 pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;
  assign space_o = (count_q <= RES_CNT_W'(RES_FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.first) + RES_PTR_W'(push_i.second);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop);
    count_d  = count_q + RES_CNT_W'(push_i.first) + RES_CNT_W'(push_i.second)
               - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      entry_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.second) begin
      entry_q[RES_PTR_W'(wr_ptr_q + 1'b1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`include "annexb_keyframe_indexer_assert.svh"

  `AKFI_ASSERT(a_count_bound, count_q <= RES_CNT_W'(RES_FIFO_DEPTH), "result buffer overflow")
  `AKFI_ASSERT_IMP(a_push_order, push_i.second, push_i.first, "second slot written alone")
  `AKFI_ASSERT(a_pop_count, (pop && !push_i.first) |=> (count_q == $past(count_q) - 1'b1), "pop miscounted")

endmodule

`default_nettype wire

@@ tb/sv/tb_annexb_keyframe_indexer.sv @@
`timescale 1ns / 100ps

import akfi_pkg::*;

// Tracks the indexer state next to the block and holds the results that the
// accepted bytes must produce, oldest first.
class index_scoreboard #(int POS_W = 31);
  localparam logic [63:0] POS_LIMIT = (64'd1 << POS_W) - 64'd1;

  logic [7:0]         window [HIST_DEPTH];
  int unsigned        fill;
  logic [63:0]        position;
  logic [63:0]        sps_offset;
  bit                 sps_seen;
  bit                 pps_seen;
  logic [FIELD_W-1:0] pictures;
  logic [FIELD_W-1:0] keyframes;

  result_t     pending_results[$];
  int unsigned mismatches;
  int unsigned keyframes_checked;
  int unsigned summaries_checked;

  function new();
    clear_stream();
    mismatches        = 0;
    keyframes_checked = 0;
    summaries_checked = 0;
  endfunction

  function void clear_stream();
    foreach (window[k]) window[k] = 8'h00;
    fill       = 0;
    position   = '0;
    sps_offset = '0;
    sps_seen   = 1'b0;
    pps_seen   = 1'b0;
    pictures   = '0;
    keyframes  = '0;
  endfunction

  function logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Called for every byte the block accepts.
  function void note_byte(logic [7:0] cur, logic last);
    logic [63:0] code_at;
    logic [63:0] code_start;
    logic [4:0]  nal;
    result_t     r;
    // window[1..3] hold the start code candidate, window[4] the NAL header
    // and cur the byte after it; window[0] may be a leading zero.
    if (fill >= 4 && window[1] == 8'h00 && window[2] == 8'h00 && window[3] == 8'h01) begin
      code_at    = (position >= 4) ? position - 4 : '0;
      code_start = (fill >= 5 && window[0] == 8'h00 && code_at > 0) ? code_at - 1 : code_at;
      nal        = window[4][4:0];
      if (nal == NAL_SPS) begin
        sps_offset = code_start;
        sps_seen   = 1'b1;
        pps_seen   = 1'b0;
      end else if (nal == NAL_PPS) begin
        if (sps_seen) pps_seen = 1'b1;
      end else if ((nal == NAL_SLICE || nal == NAL_IDR) && cur[7]) begin
        if (nal == NAL_IDR && sps_seen && pps_seen) begin
          keyframes        = bump(keyframes);
          r.kind           = KIND_KEYFRAME;
          r.start_offset   = sps_offset[FIELD_W-1:0];
          r.picture_index  = pictures;
          r.keyframe_total = keyframes;
          r.final_result   = !last;
          pending_results.push_back(r);
        end
        pictures = bump(pictures);
        sps_seen = 1'b0;
        pps_seen = 1'b0;
      end
    end

    for (int k = 0; k < HIST_DEPTH - 1; k++) window[k] = window[k+1];
    window[HIST_DEPTH-1] = cur;
    if (fill < HIST_DEPTH) fill++;
    if (position < POS_LIMIT) position++;

    if (last) begin
      r.kind           = KIND_SUMMARY;
      r.start_offset   = '0;
      r.picture_index  = pictures;
      r.keyframe_total = keyframes;
      r.final_result   = 1'b1;
      pending_results.push_back(r);
      clear_stream();
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result with nothing pending: kind=%0d off=%0d pic=%0d keys=%0d fin=%0d",
                 $time, got.kind, got.start_offset, got.picture_index,
                 got.keyframe_total, got.final_result);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind || got.start_offset !== want.start_offset ||
        got.picture_index !== want.picture_index ||
        got.keyframe_total !== want.keyframe_total ||
        got.final_result !== want.final_result) begin
      if (mismatches < 10) begin
        $display("%0t: result mismatch", $time);
        $display("  expected kind=%0d off=%0d pic=%0d keys=%0d fin=%0d",
                 want.kind, want.start_offset, want.picture_index,
                 want.keyframe_total, want.final_result);
        $display("  actual   kind=%0d off=%0d pic=%0d keys=%0d fin=%0d",
                 got.kind, got.start_offset, got.picture_index,
                 got.keyframe_total, got.final_result);
      end
      mismatches++;
    end else if (want.kind == KIND_KEYFRAME) begin
      keyframes_checked++;
    end else begin
      summaries_checked++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module tb_annexb_keyframe_indexer;

  localparam int POS_BITS      = 31;
  localparam int RANDOM_BYTES  = 1650;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [4:0] NAL_SEI = 5'd6;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;   // [7:0] stream_byte
  logic        s_axis_tlast_i  = 1'b0;    // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;            // [30:0] start_offset, [61:31] picture_index,
                                          // [92:62] keyframe_total, [95:93] zero
  logic        m_axis_tuser_o;            // result_kind
  logic        m_axis_tlast_o;            // final_result

  index_scoreboard #(POS_BITS) sb;

  stream_item_t stream_q[$];
  int unsigned  bytes_sent;
  int unsigned  streams_sent;
  int unsigned  burst_left;
  int unsigned  run_left;
  int unsigned  stall_left;

  annexb_keyframe_indexer #(
    .POSITION_WIDTH(POS_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: every accepted transfer is checked against the oldest
  // expectation. tready follows runs of readiness broken by short or long
  // stalls, with occasional long stretches that never stall.
  always @(posedge clk_i) begin
    result_t got;
    bit      ready_next;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind           = result_kind_e'(m_axis_tuser_o);
      got.start_offset   = m_axis_tdata_o[30:0];
      got.picture_index  = m_axis_tdata_o[61:31];
      got.keyframe_total = m_axis_tdata_o[92:62];
      got.final_result   = m_axis_tlast_o;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      ready_next = 1'b1;
    end else begin
      run_left = $urandom_range(1, 40);
      case ($urandom_range(0, 7))
        0, 1:    stall_left = 0;
        6:       stall_left = $urandom_range(8, 30);
        7: begin
          stall_left = 0;
          run_left   = 150;
        end
        default: stall_left = $urandom_range(1, 3);
      endcase
      ready_next = (stall_left == 0);
    end
    m_axis_tready_i <= ready_next;
  end

  function automatic void put_byte(logic [7:0] b);
    stream_item_t it;
    it.data = b;
    it.last = 1'b0;
    stream_q.push_back(it);
  endfunction

  // Payload bytes lean toward 00 and 01 so that stray and broken start codes
  // show up inside NAL units.
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // One NAL unit with a three- or four-byte start code. first_mark selects the
  // top bit of the byte after the header: 1 set, 0 clear, anything else random.
  function automatic void put_nal(logic [4:0] nal, int first_mark);
    logic [2:0] idc_bits;
    logic [7:0] lead;
    int         len;
    idc_bits = 3'($urandom);
    lead     = 8'($urandom);
    if (first_mark == 1) lead[7] = 1'b1;
    else if (first_mark == 0) lead[7] = 1'b0;
    if ($urandom_range(0, 1)) put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte({idc_bits, nal});
    put_byte(lead);
    len = $urandom_range(0, 5);
    repeat (len) put_byte(filler_byte());
  endfunction

  // Builds one stream: mostly access units of parameter sets and slices in
  // varied order, some pure noise, and some streams cut short at random.
  function automatic void make_stream();
    int style;
    int units;
    int cut;
    stream_q.delete();
    style = $urandom_range(0, 9);
    if (style == 8) begin
      repeat ($urandom_range(1, 40)) put_byte(filler_byte());
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) put_byte(filler_byte());
      units = $urandom_range(1, 6);
      repeat (units) begin
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 5) != 0) put_nal(NAL_SPS, 2);
          if ($urandom_range(0, 5) != 0) put_nal(NAL_PPS, 2);
          if ($urandom_range(0, 3) == 0) put_nal(NAL_SEI, 2);
          put_nal(NAL_IDR, ($urandom_range(0, 7) != 0) ? 1 : 0);
          if ($urandom_range(0, 2) == 0) put_nal(NAL_IDR, 0);
        end else begin
          case ($urandom_range(0, 4))
            0:       put_nal(NAL_SLICE, 1);
            1:       put_nal(NAL_SLICE, 0);
            2:       put_nal(NAL_PPS, 2);
            3:       put_nal(NAL_SPS, 2);
            default: put_nal(5'($urandom), 2);
          endcase
        end
      end
      if (style == 9 && stream_q.size() > 1) begin
        cut      = $urandom_range(0, stream_q.size() - 1);
        stream_q = stream_q[0:cut];
      end
    end
    stream_q[$].last = 1'b1;
  endfunction

  function automatic void load_stream(logic [7:0] bytes_in[$]);
    stream_q.delete();
    foreach (bytes_in[k]) put_byte(bytes_in[k]);
    stream_q[$].last = 1'b1;
  endfunction

  // Sends the queued stream. Transfers come in bursts of random length, with
  // a random gap, sometimes none, before each burst.
  task automatic send_stream();
    int gap;
    foreach (stream_q[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        case ($urandom_range(0, 9))
          0, 1:    gap = 0;
          2:       gap = $urandom_range(10, 24);
          default: gap = $urandom_range(1, 4);
        endcase
        if (gap > 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= stream_q[k].data;
      s_axis_tlast_i  <= stream_q[k].last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      sb.note_byte(stream_q[k].data, stream_q[k].last);
      bytes_sent++;
    end
    streams_sent++;
  endtask

  // Holds the input back until every expected result has come out.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    logic [7:0]  seq[$];
    int unsigned directed_bytes;
    int unsigned leftover;
    sb         = new();
    bytes_sent = 0;
    streams_sent = 0;
    burst_left = 0;
    run_left   = 0;
    stall_left = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // SPS with a leading zero byte at offset 0, then PPS, then an IDR first
    // slice whose first-slice byte is also the final byte: the keyframe
    // entry comes before the summary.
    seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01, 8'h68,
            8'hce, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80};
    load_stream(seq);
    send_stream();
    // Shortest stream that can still judge a start code: a non-IDR picture
    // judged on the final byte, all-ones byte included.
    seq = '{8'h00, 8'h00, 8'h01, 8'he1, 8'hff};
    load_stream(seq);
    send_stream();
    // Too short to find anything.
    seq = '{8'h00, 8'h01};
    load_stream(seq);
    send_stream();
    directed_bytes = bytes_sent;
    drain_results();

    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      make_stream();
      send_stream();
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    leftover = sb.outstanding();
    if (leftover != 0)
      $display("%0d expected results never came out", leftover);

    $display("Sent %0d stream bytes in %0d streams under random gaps and output stalls.",
             bytes_sent, streams_sent);
    $display("Checked %0d keyframe entries and %0d end-of-stream summaries, %0d mismatches.",
             sb.keyframes_checked, sb.summaries_checked, sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Generous upper bound on the whole run.
  initial begin
    #10_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
